// ===== src/pfac_pkg.sv =====
// Shared types, character codes and the per-byte parse step of the argument counter.
`default_nettype none
package pfac_pkg;

    localparam int COUNT_BITS = 10;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Characters that steer the parse
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_Q       = 8'h71;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_L_LOW   = 8'h6C;
    localparam logic [7:0] CH_L_UP    = 8'h4C;
    localparam logic [7:0] CH_J       = 8'h6A;
    localparam logic [7:0] CH_Z       = 8'h7A;
    localparam logic [7:0] CH_T       = 8'h74;

    typedef enum logic [3:0] {
        PH_TEXT        = 4'd0,
        PH_PCT         = 4'd1,
        PH_FLAGS       = 4'd2,
        PH_WIDTH       = 4'd3,
        PH_DOT         = 4'd4,
        PH_PREC_START  = 4'd5,
        PH_PREC_DIGITS = 4'd6,
        PH_LENGTH      = 4'd7,
        PH_GROUP       = 4'd8,
        PH_CONV        = 4'd9
    } phase_t;

    // Registered input byte handed to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] format_byte;
        logic       last_byte;
    } byte_stage_t;

    // Outcome of one byte
    typedef struct packed {
        phase_t phase;
        logic   bump;
        logic   quote;
    } step_t;

    // Walk the byte through every phase it falls through; at most one bump per byte
    function automatic step_t parse_step(input phase_t cur, input logic [7:0] b,
                                         input logic last);
        step_t  res;
        phase_t ph;
        logic   done;
        res.phase = cur;
        res.bump  = 1'b0;
        res.quote = 1'b0;
        ph        = cur;
        done      = 1'b0;
        case (cur)
            PH_TEXT:
            begin
                done = 1'b1;
                if (b == CH_PERCENT && !last)
                    res.phase = PH_PCT;
            end
            PH_GROUP:
            begin
                done = 1'b1;
                if (b == CH_RPAREN)
                    res.phase = PH_CONV;
            end
            PH_PCT, PH_FLAGS, PH_WIDTH, PH_DOT, PH_PREC_START, PH_PREC_DIGITS,
            PH_LENGTH, PH_CONV:
            begin
                done = 1'b0;
            end
            default:
            begin
                done      = 1'b1;
                res.phase = PH_TEXT;
            end
        endcase
        if (!done && ph == PH_PCT)
        begin
            if (b == CH_PERCENT)
            begin
                res.phase = PH_TEXT;
                done      = 1'b1;
            end
            else
                ph = PH_FLAGS;
        end
        if (!done && ph == PH_FLAGS)
        begin
            if (b inside {CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_ZERO})
            begin
                res.phase = PH_FLAGS;
                done      = 1'b1;
            end
            else if (b == CH_STAR)
            begin
                res.bump  = 1'b1;
                res.phase = PH_DOT;
                done      = 1'b1;
            end
            else
                ph = PH_WIDTH;
        end
        if (!done && ph == PH_WIDTH)
        begin
            if (b inside {[CH_ZERO:CH_NINE]})
            begin
                res.phase = PH_WIDTH;
                done      = 1'b1;
            end
            else
                ph = PH_DOT;
        end
        if (!done && ph == PH_DOT)
        begin
            if (b == CH_DOT)
            begin
                res.phase = PH_PREC_START;
                done      = 1'b1;
            end
            else
                ph = PH_LENGTH;
        end
        if (!done && ph == PH_PREC_START)
        begin
            if (b == CH_STAR)
            begin
                res.bump  = 1'b1;
                res.phase = PH_LENGTH;
                done      = 1'b1;
            end
            else
                ph = PH_PREC_DIGITS;
        end
        if (!done && ph == PH_PREC_DIGITS)
        begin
            if (b inside {[CH_ZERO:CH_NINE]})
            begin
                res.phase = PH_PREC_DIGITS;
                done      = 1'b1;
            end
            else
                ph = PH_LENGTH;
        end
        if (!done && ph == PH_LENGTH)
        begin
            if (b inside {CH_H, CH_L_LOW, CH_L_UP, CH_J, CH_Z, CH_T})
            begin
                res.phase = PH_LENGTH;
                done      = 1'b1;
            end
            else if (b == CH_LPAREN)
            begin
                res.phase = PH_GROUP;
                done      = 1'b1;
            end
            else
                ph = PH_CONV;
        end
        if (!done && ph == PH_CONV)
        begin
            res.quote = (b == CH_Q);
            res.bump  = 1'b1;
            res.phase = PH_TEXT;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/pfac_in_if.sv =====
// Format byte channel: valid/ready handshake with one byte and its end mark.
`default_nettype none
interface pfac_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] format_byte;
    logic       last_byte;

    modport source (output valid, output format_byte, output last_byte, input ready);
    modport sink (input valid, input format_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== src/pfac_out_if.sv =====
// Result channel: valid/ready handshake with the argument count and quote flag.
`default_nettype none
interface pfac_out_if;
    logic                           valid;
    logic                           ready;
    logic [pfac_pkg::COUNT_BITS-1:0] arg_count;
    logic                           uses_quote;

    modport source (output valid, output arg_count, output uses_quote, input ready);
    modport sink (input valid, input arg_count, input uses_quote, output ready);
endinterface
`default_nettype wire

// ===== src/pfac_in_stage.sv =====
// Input register: captures one format byte per transfer for the parser.
`default_nettype none
module pfac_in_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    pfac_in_if.sink                    fmt,
    input  wire logic                  take,
    output pfac_pkg::byte_stage_t      stage
);
    import pfac_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;

    // Accept a new byte whenever the register is empty or draining this cycle
    assign fmt.ready  = !valid_reg || take;
    assign load       = fmt.valid && fmt.ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the payload on a transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= fmt.format_byte;
            last_reg <= fmt.last_byte;
        end
    end

    assign stage.valid       = valid_reg;
    assign stage.format_byte = byte_reg;
    assign stage.last_byte   = last_reg;

endmodule
`default_nettype wire

// ===== src/pfac_parser.sv =====
// Parse state, saturating argument count and result register.
`default_nettype none
module pfac_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pfac_pkg::byte_stage_t stage,
    output logic                       take,
    pfac_out_if.source                 result
);
    import pfac_pkg::*;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  quote_reg;
    logic                  quote_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COUNT_BITS-1:0] arg_count_reg;
    logic                  uses_quote_reg;
    logic                  slot_free;
    logic                  finish;
    step_t                 step;
    logic                  tail_bump;
    logic [1:0]            inc;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] count_sat;
    logic                  quote_sum;

    // Drain a byte unless it ends the string and the result slot is busy
    assign slot_free = !out_valid_reg || result.ready;
    assign take      = stage.valid && (!stage.last_byte || slot_free);
    assign finish    = take && stage.last_byte;

    // Advance the parse by one byte
    assign step      = parse_step(phase_reg, stage.format_byte, stage.last_byte);
    assign tail_bump = stage.last_byte && (step.phase != PH_TEXT) &&
                       (step.phase != PH_PCT) && (step.phase != PH_FLAGS);
    assign inc       = {1'b0, step.bump} + {1'b0, tail_bump};
    assign sum       = {1'b0, count_reg} + {{(COUNT_BITS-1){1'b0}}, inc};
    assign count_sat = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
    assign quote_sum = quote_reg | step.quote;

    // Advance on a drained byte; return to the start after the final byte
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        quote_next = quote_reg;
        if (take)
        begin
            if (stage.last_byte)
            begin
                phase_next = PH_TEXT;
                count_next = '0;
                quote_next = 1'b0;
            end
            else
            begin
                phase_next = step.phase;
                count_next = count_sat;
                quote_next = quote_sum;
            end
        end
    end

    assign out_valid_next = finish ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    // Hold parse state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TEXT;
            count_reg     <= '0;
            quote_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            quote_reg     <= quote_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload on the final byte
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            arg_count_reg  <= count_sat;
            uses_quote_reg <= quote_sum;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.arg_count  = arg_count_reg;
    assign result.uses_quote = uses_quote_reg;

    // A final byte leaves a clean parse state and a pending result
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (phase_reg == PH_TEXT) && (count_reg == '0) && !quote_reg)
        else $error("parse state not cleared after final byte");

    a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg)
        else $error("final byte produced no result");

    // The count only grows within one string
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !stage.last_byte) |=> count_reg >= $past(count_reg))
        else $error("running count decreased");

    // Parse state moves only on a drained byte
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(phase_reg) && $stable(count_reg))
        else $error("parse state changed without a byte");

    // A final byte is never drained over an unread result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && out_valid_reg) |-> result.ready)
        else $error("result overwritten before transfer");

endmodule
`default_nettype wire

// ===== src/printf_format_argument_counter.sv =====
// Top level of the printf format argument counter.
//
// Usage:
//   fmt carries the format string one byte per transfer; last_byte marks the
//   final byte. After the final byte, result carries one item: arg_count, the
//   number of arguments the conversions consume (saturating at 1023), and
//   uses_quote, set if any conversion character was 'q'. Other bytes give no
//   result.
// Timing:
//   One byte per cycle, sustained, while no final byte waits on a busy result
//   register. A byte is held in the input register, then the parse step
//   updates the state; the final byte's drain loads the result register.
//   The single parse step between the two registers sets the rate.
// Reset:
//   rst_n clears the parse state, the count, the quote flag and both valid
//   flags; the block then waits in plain text.
// Back-pressure:
//   Non-final bytes keep flowing while a result waits. A final byte waits in
//   the input register until the result register is free, and fmt.ready
//   drops only then.
`default_nettype none
module printf_format_argument_counter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pfac_in_if.sink    fmt,
    pfac_out_if.source result
);
    import pfac_pkg::*;

    byte_stage_t stage;
    logic        take;

    pfac_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .fmt   (fmt),
        .take  (take),
        .stage (stage)
    );

    pfac_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .stage  (stage),
        .take   (take),
        .result (result)
    );

endmodule
`default_nettype wire
